[sv/plp_pkg.sv]
`timescale 1ns / 1ps
// Package for the positional ordered list unit: field widths, request and
// status codes, the cell command type and the controller state type.
// No dependencies.
package plp_pkg;

    // Default and largest supported capacity of the cell row.
    localparam int CAPACITY_DEF = 16;
    localparam int CAPACITY_MAX = 64;

    // Width of positions, indexes and counts inside the block (covers CAPACITY_MAX).
    localparam int PTR_W = $clog2(CAPACITY_MAX + 1);

    localparam int REQ_W  = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam int S_TDATA_BITS = POS_W + VAL_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = VAL_W + LEN_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_TRAVERSE  = 3'd6
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op         op;
        logic [PTR_W-1:0] at;    // insert or delete position
        logic [PTR_W-1:0] tail;  // index of the last occupied cell
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_TRAV
    } t_state;

endpackage

[sv/plp_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the ordered list row. It holds one element and takes
// its next value from itself, its neighbours, the new word or the wrap value.
// Depends on plp_pkg.
module plp_cell #(
    parameter int INDEX = 0
) (
    input  logic                               i_clk,
    input  plp_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [plp_pkg::VAL_W-1:0]   i_new,
    input  logic signed [plp_pkg::VAL_W-1:0]   i_left,
    input  logic signed [plp_pkg::VAL_W-1:0]   i_right,
    input  logic signed [plp_pkg::VAL_W-1:0]   i_wrap,
    output logic signed [plp_pkg::VAL_W-1:0]   o_value
);

    localparam logic [plp_pkg::PTR_W-1:0] MY_IDX = plp_pkg::PTR_W'(INDEX);

    logic signed [plp_pkg::VAL_W-1:0] r_value;
    logic signed [plp_pkg::VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            plp_pkg::CELL_INS: begin
                if (MY_IDX > i_ctl.at) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctl.at) begin
                    n_value = i_new;
                end
            end
            plp_pkg::CELL_DEL: begin
                if (MY_IDX >= i_ctl.at) begin
                    n_value = i_right;
                end
            end
            plp_pkg::CELL_ROT: begin
                // The occupied part of the row turns by one place towards cell zero.
                if (MY_IDX == i_ctl.tail) begin
                    n_value = i_wrap;
                end else if (MY_IDX < i_ctl.tail) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[sv/positional_ordered_list_unit.sv]
`timescale 1ns / 1ps
// Positional ordered list unit: a bounded ordered list of signed 32-bit
// elements held in a row of cells, with insert, delete and traverse requests.
// Depends on plp_pkg and plp_cell.

// Inserts and deletes shift the cell row by one place as the request is taken
// and register one result word with status and the new length, so a stream of
// mutations runs at one word per cycle while the output is taken. A traverse of
// n elements gives n result words, one per cycle while the output register is
// free, by turning the occupied cells past cell zero; it holds off input until
// the last one is registered, and gives a single status word when the list is
// empty. Input is also held while the output register is full and not being
// taken. The cell contents are not reset; only occupied cells are ever read,
// so no clearing pass follows reset. Request code 7 is taken and ignored.
module positional_ordered_list_unit #(
    parameter int CAPACITY = plp_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [4:0] position, [36:5] item_value, [39:37] zero
    input  logic [plp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] req_type
    input  logic [plp_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] read_value, [36:32] list_length, [39:37] zero
    output logic [plp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [plp_pkg::STAT_W-1:0]     m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [plp_pkg::PTR_W-1:0] CAP_P = plp_pkg::PTR_W'(CAPACITY);

    plp_pkg::t_state                    r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_left, n_left;
    logic                               r_out_valid;
    plp_pkg::t_status                   r_status, n_status;
    logic signed [plp_pkg::VAL_W-1:0]   r_value, n_value;
    logic [plp_pkg::LEN_W-1:0]          r_len;
    logic                               r_last, n_last;

    logic                               w_slot_free;
    logic                               w_accept;
    logic                               w_load;
    plp_pkg::t_req                      w_req;
    logic [plp_pkg::PTR_W-1:0]          w_pos;
    logic signed [plp_pkg::VAL_W-1:0]   w_item;
    logic [plp_pkg::PTR_W-1:0]          w_count_p;
    logic [plp_pkg::PTR_W-1:0]          w_n_count_p;
    plp_pkg::t_cell_ctl                 w_ctl;
    logic signed [plp_pkg::VAL_W-1:0]   w_cell [CAPACITY];

    assign w_req     = plp_pkg::t_req'(s_axis_tuser);
    assign w_pos     = plp_pkg::PTR_W'(s_axis_tdata[plp_pkg::POS_W-1:0]);
    assign w_item    = s_axis_tdata[plp_pkg::POS_W +: plp_pkg::VAL_W];
    assign w_count_p = plp_pkg::PTR_W'(r_count);
    assign w_n_count_p = plp_pkg::PTR_W'(n_count);

    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // Cell row.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [plp_pkg::VAL_W-1:0] w_l;
        logic signed [plp_pkg::VAL_W-1:0] w_r;
        if (g == 0) begin : g_first
            assign w_l = w_item;
        end else begin : g_mid_l
            assign w_l = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r = '0;
        end else begin : g_mid_r
            assign w_r = w_cell[g+1];
        end
        plp_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (w_item),
            .i_left  (w_l),
            .i_right (w_r),
            .i_wrap  (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plp_pkg::ST_IDLE: begin
                if (w_accept && w_req == plp_pkg::REQ_TRAVERSE && r_count != '0) begin
                    n_state = plp_pkg::ST_TRAV;
                end
            end
            plp_pkg::ST_TRAV: begin
                if (w_slot_free && r_left == CW'(1)) begin
                    n_state = plp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: handshake, cell command and result word.
    always_comb begin
        logic [plp_pkg::PTR_W-1:0] v_at;
        s_axis_tready = 1'b0;
        w_ctl.op      = plp_pkg::CELL_HOLD;
        w_ctl.at      = '0;
        w_ctl.tail    = w_count_p - plp_pkg::PTR_W'(1);
        w_load        = 1'b0;
        n_status      = plp_pkg::STAT_OK;
        n_value       = '0;
        n_last        = 1'b1;
        n_count       = r_count;
        n_left        = r_left;
        v_at          = '0;
        unique case (r_state)
            plp_pkg::ST_IDLE: begin
                s_axis_tready = w_slot_free;
                if (w_accept) begin
                    unique case (w_req)
                        plp_pkg::REQ_INS_FRONT, plp_pkg::REQ_INS_BACK,
                        plp_pkg::REQ_INS_AT: begin
                            if (w_req == plp_pkg::REQ_INS_FRONT) begin
                                v_at = '0;
                            end else if (w_req == plp_pkg::REQ_INS_BACK) begin
                                v_at = w_count_p;
                            end else begin
                                v_at = w_pos;
                            end
                            w_load = 1'b1;
                            if (w_count_p >= CAP_P) begin
                                n_status = plp_pkg::STAT_FULL;
                            end else if (v_at > w_count_p) begin
                                n_status = plp_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = plp_pkg::CELL_INS;
                                w_ctl.at = v_at;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        plp_pkg::REQ_DEL_FRONT, plp_pkg::REQ_DEL_BACK,
                        plp_pkg::REQ_DEL_AT: begin
                            if (w_req == plp_pkg::REQ_DEL_FRONT) begin
                                v_at = '0;
                            end else if (w_req == plp_pkg::REQ_DEL_BACK) begin
                                v_at = w_count_p - plp_pkg::PTR_W'(1);
                            end else begin
                                v_at = w_pos;
                            end
                            w_load = 1'b1;
                            if (r_count == '0) begin
                                n_status = plp_pkg::STAT_EMPTY;
                            end else if (v_at >= w_count_p) begin
                                n_status = plp_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = plp_pkg::CELL_DEL;
                                w_ctl.at = v_at;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        plp_pkg::REQ_TRAVERSE: begin
                            if (r_count == '0) begin
                                w_load   = 1'b1;
                                n_status = plp_pkg::STAT_EMPTY;
                            end else begin
                                n_left = r_count;
                            end
                        end
                        default: begin
                            w_load = 1'b0;
                        end
                    endcase
                end
            end
            plp_pkg::ST_TRAV: begin
                if (w_slot_free) begin
                    w_load   = 1'b1;
                    n_value  = w_cell[0];
                    n_last   = (r_left == CW'(1));
                    w_ctl.op = plp_pkg::CELL_ROT;
                    n_left   = r_left - CW'(1);
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plp_pkg::ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_len    <= w_n_count_p[plp_pkg::LEN_W-1:0];
            r_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(plp_pkg::M_TDATA_W - plp_pkg::M_TDATA_BITS){1'b0}},
                            r_len, r_value};

    // The element count never passes the capacity of the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_p <= CAP_P)
        else $error("element count above capacity");

    // No request is taken while a traverse is still giving out words.
    a_trav_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == plp_pkg::ST_TRAV |-> !s_axis_tready)
        else $error("input taken during traverse");

    // A traverse in progress always has at least one word left to give.
    a_trav_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == plp_pkg::ST_TRAV |-> (r_left != '0 && r_left <= r_count))
        else $error("traverse counter out of step with the list");

    // Every accepted insert or delete leaves a result word waiting next cycle.
    a_mut_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_req == plp_pkg::REQ_INS_FRONT || w_req == plp_pkg::REQ_INS_BACK
            || w_req == plp_pkg::REQ_INS_AT || w_req == plp_pkg::REQ_DEL_FRONT
            || w_req == plp_pkg::REQ_DEL_BACK || w_req == plp_pkg::REQ_DEL_AT))
        |=> m_axis_tvalid)
        else $error("mutation gave no result word");

endmodule
